[rtl/bessel_i0_poly_eval_macros.svh]
// Assertion macros used by the checker file.
`ifndef BESSEL_I0_POLY_EVAL_MACROS_SVH
`define BESSEL_I0_POLY_EVAL_MACROS_SVH

// Implication that is switched off while reset is asserted.
`define BI0_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bi0 checker: property violated");

// Next-cycle implication that is checked during reset as well.
`define BI0_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bi0 checker: property violated");

`endif

[rtl/bi0_pkg.sv]
`default_nettype none
package bi0_pkg;

  // Number of series terms and fraction bits of the argument.
  localparam int NUM_TERMS    = 14;
  localparam int IN_FRAC_BITS = 12;
  localparam int MAX_TERMS    = 20;

  // Terms actually used, held to the supported range.
  localparam int TERMS     = (NUM_TERMS < 1) ? 1 :
                             ((NUM_TERMS > MAX_TERMS) ? MAX_TERMS : NUM_TERMS);
  localparam int NUM_STEPS = TERMS - 1;

  localparam int X_W    = 16;
  localparam int SQ_W   = 2 * X_W;
  localparam int U_W    = 33;
  localparam int ACC_W  = 61;
  localparam int FRAC_U = 30;
  localparam int OUT_W  = 32;

  // Alignment of the squared argument onto 30 fraction bits.
  localparam int U_SH  = 2 * IN_FRAC_BITS - 24;
  localparam int U_SHR = (U_SH >= 0) ? U_SH : 0;
  localparam int U_SHL = (U_SH < 0) ? -U_SH : 0;
  localparam int U_WIDE_W = SQ_W + U_SHL + 1;

  localparam logic [U_W-1:0]   U_CAP   = U_W'(1) << 32;
  localparam logic [ACC_W-1:0] ACC_CAP = ACC_W'(1) << 60;

  // b_n = 16^n / (n!)^2 in unsigned Q.40, rounded to nearest.
  localparam logic [ACC_W-1:0] COEF [MAX_TERMS] = '{
    61'd1099511627776,
    61'd17592186044416,
    61'd70368744177664,
    61'd125099989649180,
    61'd125099989649180,
    61'd80063993375475,
    61'd35583997055767,
    61'd11619264344740,
    61'd2904816086185,
    61'd573790831839,
    61'd91806533094,
    61'd12139706855,
    61'd1348856317,
    61'd127702373,
    61'd10424684,
    61'd741311,
    61'd46332,
    61'd2565,
    61'd127,
    61'd6
  };

  // One lane of the Horner chain as it travels between pipeline sections.
  typedef struct packed {
    logic             valid;
    logic [U_W-1:0]   u;
    logic [ACC_W-1:0] acc;
  } bi0_lane_t;

  // Scales the square onto 30 fraction bits and clamps it at 4.0.
  function automatic logic [U_W-1:0] scale_u(input logic [SQ_W-1:0] sq);
    logic [U_WIDE_W-1:0] wide;
    wide = (U_WIDE_W'(sq) << U_SHL) >> U_SHR;
    if (wide > U_WIDE_W'(U_CAP)) begin
      return U_CAP;
    end
    return wide[U_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/bi0_square.sv]
`default_nettype none
module bi0_square (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic signed [bi0_pkg::X_W-1:0] x_sample,
  output bi0_pkg::bi0_lane_t              lane_r
);

  logic [bi0_pkg::X_W-1:0]  mag;
  logic [bi0_pkg::SQ_W-1:0] sq;
  bi0_pkg::bi0_lane_t       lane_nxt;

  // The magnitude of the most negative code still fits as an unsigned value.
  always_comb begin
    mag = x_sample[bi0_pkg::X_W-1] ? bi0_pkg::X_W'(-x_sample) : bi0_pkg::X_W'(x_sample);
    sq  = bi0_pkg::SQ_W'(mag) * bi0_pkg::SQ_W'(mag);
    lane_nxt.valid = in_valid;
    lane_nxt.u     = bi0_pkg::scale_u(sq);
    lane_nxt.acc   = bi0_pkg::COEF[bi0_pkg::TERMS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      lane_r.u   <= lane_nxt.u;
      lane_r.acc <= lane_nxt.acc;
    end
  end

endmodule
`default_nettype wire

[rtl/bi0_horner_step.sv]
`default_nettype none
module bi0_horner_step (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [bi0_pkg::ACC_W-1:0]     coef,
  input  wire bi0_pkg::bi0_lane_t            lane_in,
  output bi0_pkg::bi0_lane_t                 lane_r
);

  localparam int HI_W   = bi0_pkg::ACC_W - bi0_pkg::FRAC_U;
  localparam int HP_W   = HI_W + bi0_pkg::U_W;
  localparam int LP_W   = bi0_pkg::FRAC_U + bi0_pkg::U_W;
  localparam int LS_W   = LP_W - bi0_pkg::FRAC_U;
  localparam int SUM_W  = HP_W + 1;

  // First half: the two partial products of acc * u.
  logic                        mid_valid_r, mid_valid_nxt;
  logic [bi0_pkg::U_W-1:0]     mid_u_r, mid_u_nxt;
  logic [HP_W-1:0]             mid_hi_r, mid_hi_nxt;
  logic [LS_W-1:0]             mid_lo_r, mid_lo_nxt;
  logic [LP_W-1:0]             lo_prod;

  // Second half: recombine, saturate, add the coefficient, saturate.
  logic [SUM_W-1:0]            prod_sum;
  logic [bi0_pkg::ACC_W-1:0]   prod_sat;
  logic [bi0_pkg::ACC_W:0]     acc_sum;
  bi0_pkg::bi0_lane_t          lane_nxt;

  always_comb begin
    mid_valid_nxt = lane_in.valid;
    mid_u_nxt     = lane_in.u;
    mid_hi_nxt    = HP_W'(lane_in.acc[bi0_pkg::ACC_W-1:bi0_pkg::FRAC_U]) * HP_W'(lane_in.u);
    lo_prod       = LP_W'(lane_in.acc[bi0_pkg::FRAC_U-1:0]) * LP_W'(lane_in.u);
    mid_lo_nxt    = lo_prod[LP_W-1:bi0_pkg::FRAC_U];
  end

  always_comb begin
    prod_sum = SUM_W'(mid_hi_r) + SUM_W'(mid_lo_r);
    if (prod_sum > SUM_W'(bi0_pkg::ACC_CAP)) begin
      prod_sat = bi0_pkg::ACC_CAP;
    end else begin
      prod_sat = prod_sum[bi0_pkg::ACC_W-1:0];
    end
    acc_sum = {1'b0, prod_sat} + {1'b0, coef};
    lane_nxt.valid = mid_valid_r;
    lane_nxt.u     = mid_u_r;
    if (acc_sum > {1'b0, bi0_pkg::ACC_CAP}) begin
      lane_nxt.acc = bi0_pkg::ACC_CAP;
    end else begin
      lane_nxt.acc = acc_sum[bi0_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r  <= 1'b0;
      lane_r.valid <= 1'b0;
    end else if (en) begin
      mid_valid_r  <= mid_valid_nxt;
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      mid_u_r    <= mid_u_nxt;
      mid_hi_r   <= mid_hi_nxt;
      mid_lo_r   <= mid_lo_nxt;
      lane_r.u   <= lane_nxt.u;
      lane_r.acc <= lane_nxt.acc;
    end
  end

endmodule
`default_nettype wire

[rtl/bessel_i0_poly_eval.sv]
// Throughput: one sample per cycle while no held result stalls the chain.
// Each Horner step is a two-stage multiply and add section.
// The whole chain advances together, so a stalled result holds every stage in place.
// Reset is synchronous and active low; it clears the valid bits of all stages only.
`default_nettype none
module bessel_i0_poly_eval (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [bi0_pkg::X_W-1:0]     in_x_sample,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [bi0_pkg::OUT_W-1:0]               out_i0_value
);

  localparam int RND_W = bi0_pkg::ACC_W + 1;
  localparam int RES_W = RND_W - 18;

  // The pipeline moves whenever the output register is empty or being drained.
  // A new sample is refused only while a finished result is held by the sink.
  logic en;

  // lanes[0] leaves the squaring stage, lanes[k+1] leaves Horner step k.
  bi0_pkg::bi0_lane_t lanes [bi0_pkg::NUM_STEPS+1];

  logic                         out_valid_r, out_valid_nxt;
  logic [bi0_pkg::OUT_W-1:0]    out_value_r, out_value_nxt;
  logic [RND_W-1:0]             rnd;
  logic [RES_W-1:0]             res;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Squaring stage: |x|^2 aligned onto 30 fraction bits and clamped at 4.0,
  // with the accumulator seeded by the highest-order coefficient.
  bi0_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .x_sample (in_x_sample),
    .lane_r   (lanes[0])
  );

  // Horner chain, highest coefficient first. Each step computes
  // acc = b_n + floor(acc * u / 2^30), saturating at 2^60.
  for (genvar k = 0; k < bi0_pkg::NUM_STEPS; k++) begin : g_step
    bi0_horner_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .coef    (bi0_pkg::COEF[bi0_pkg::TERMS-2-k]),
      .lane_in (lanes[k]),
      .lane_r  (lanes[k+1])
    );
  end

  // Output stage: round half up from Q.40 to Q10.22 and saturate to 32 bits.
  always_comb begin
    rnd = RND_W'(lanes[bi0_pkg::NUM_STEPS].acc) + (RND_W'(1) << 17);
    res = rnd[RND_W-1:18];
    out_valid_nxt = lanes[bi0_pkg::NUM_STEPS].valid;
    if (|res[RES_W-1:bi0_pkg::OUT_W]) begin
      out_value_nxt = '1;
    end else begin
      out_value_nxt = res[bi0_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
    if (en) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_i0_value = out_value_r;

endmodule
`default_nettype wire

[rtl/bi0_checker.sv]
`default_nettype none
`include "bessel_i0_poly_eval_macros.svh"
module bi0_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic signed [bi0_pkg::X_W-1:0] in_x_sample,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [bi0_pkg::OUT_W-1:0]      out_i0_value
);

  // A sample that is held back by the block stays offered and unchanged.
  `BI0_ASSERT_NEXT(a_in_hold, rst_n && in_valid && in_stall, in_valid && $stable(in_x_sample))

  // A result that is held by the sink stays offered.
  `BI0_ASSERT_NEXT(a_out_hold, rst_n && out_valid && out_stall, out_valid)

  // After a reset cycle no stale result is offered.
  `BI0_ASSERT_NEXT(a_reset_empty, !rst_n, !out_valid)

  // The input is refused only while a finished result is waiting.
  `BI0_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

  // Every term is positive and the constant term is one, so I0 never drops below 1.0.
  `BI0_ASSERT_IMP(a_floor_one, out_valid, out_i0_value >= 32'h0040_0000)

endmodule

bind bessel_i0_poly_eval bi0_checker u_bi0_checker (.*);
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  // The clock period is 12 ns. Reset is asserted only at the start and never again.
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 5;

  // PIPE_LATENCY is the pipeline depth from input transfer to result, and DRAIN_CYCLES, the
  // length of the drain at the end, is derived from it.
  localparam int PIPE_LATENCY = 2 * (bi0_pkg::NUM_TERMS - 1) + 2;
  localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY + 8;

  // The watchdog trips after this many consecutive cycles in which neither channel completes
  // a transfer. Even the longest random stall is far shorter than this.
  localparam int STALL_LIMIT = 5000;

  // Each side idles in roughly this many cycles out of a hundred.
  localparam int IDLE_PERCENT = 29;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [bi0_pkg::X_W-1:0] in_x_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bi0_pkg::OUT_W-1:0] out_i0_value;

  // While this is set, neither side inserts idle cycles. It is used for a back-to-back
  // stretch and for the final drain.
  bit no_idle = 1'b0;

  // The I0 values still to come, oldest first, together with the argument that produced
  // each one.
  logic [bi0_pkg::OUT_W-1:0] pending_i0[$];
  logic signed [bi0_pkg::X_W-1:0] pending_x[$];

  int error_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int quiet_cycles = 0;

  bessel_i0_poly_eval i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x_sample  (in_x_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_i0_value (out_i0_value)
  );

  always #HALF_PERIOD clk = ~clk;

  // This table holds the series coefficients 16^n/(n!)^2 in unsigned Q.40, rounded to the
  // nearest value.
  function automatic logic [63:0] series_coef(input int n);
    case (n)
      0:       return 64'd1099511627776;
      1:       return 64'd17592186044416;
      2:       return 64'd70368744177664;
      3:       return 64'd125099989649180;
      4:       return 64'd125099989649180;
      5:       return 64'd80063993375475;
      6:       return 64'd35583997055767;
      7:       return 64'd11619264344740;
      8:       return 64'd2904816086185;
      9:       return 64'd573790831839;
      10:      return 64'd91806533094;
      11:      return 64'd12139706855;
      12:      return 64'd1348856317;
      13:      return 64'd127702373;
      14:      return 64'd10424684;
      15:      return 64'd741311;
      16:      return 64'd46332;
      17:      return 64'd2565;
      18:      return 64'd127;
      default: return 64'd6;
    endcase
  endfunction

  // This function gives the expected I0(x) in Q10.22. The square is aligned onto 30 fraction
  // bits and clamped at 4.0. Horner's rule then runs in Q.40, and the accumulator saturates at
  // 2^60 after each multiply and after each add. The last step rounds half up to 22 fraction
  // bits and saturates to 32 bits.
  function automatic logic [bi0_pkg::OUT_W-1:0] bessel_i0_fixed(
      input logic signed [bi0_pkg::X_W-1:0] x);
    int xs;
    int shift;
    int terms;
    int n;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] u;
    logic [63:0] acc;
    logic [63:0] prod;
    logic [63:0] rounded;
    xs = x;
    mag = (xs < 0) ? 64'(-xs) : 64'(xs);
    sq = mag * mag;
    shift = 2 * bi0_pkg::IN_FRAC_BITS - 24;
    if (shift >= 0) begin
      u = (shift >= 63) ? 64'd0 : (sq >> shift);
    end else begin
      u = (-shift >= 32) ? (64'd1 << 32) : (sq << (-shift));
    end
    if (u > (64'd1 << 32)) begin
      u = 64'd1 << 32;
    end
    terms = bi0_pkg::NUM_TERMS;
    if (terms < 1) begin
      terms = 1;
    end
    if (terms > 20) begin
      terms = 20;
    end
    acc = series_coef(terms - 1);
    for (n = terms - 2; n >= 0; n--) begin
      prod = (acc >> 30) * u + (((acc & ((64'd1 << 30) - 1)) * u) >> 30);
      if (prod > (64'd1 << 60)) begin
        prod = 64'd1 << 60;
      end
      acc = prod + series_coef(n);
      if (acc > (64'd1 << 60)) begin
        acc = 64'd1 << 60;
      end
    end
    rounded = (acc + (64'd1 << 17)) >> 18;
    if (rounded > 64'h0000_0000_FFFF_FFFF) begin
      rounded = 64'h0000_0000_FFFF_FFFF;
    end
    return rounded[bi0_pkg::OUT_W-1:0];
  endfunction

  // The receiving side asserts stall at random on the falling edge, unless a stretch with
  // no idling is in force.
  always @(negedge clk) begin
    if (!rst_n || no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // Both channels are watched at the rising edge, where every input has been stable since
  // the falling edge. When an input transfer completes, its expected I0 value is queued. When
  // a result transfer completes, it is checked against the oldest entry in that queue.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_i0.push_back(bessel_i0_fixed(in_x_sample));
        pending_x.push_back(in_x_sample);
      end
      if (out_valid && !out_stall) begin
        if (pending_i0.size() == 0) begin
          $error("i0_value: unexpected result %h with nothing outstanding", out_i0_value);
          error_count++;
        end else begin
          if (out_i0_value !== pending_i0[0]) begin
            $error("i0_value: expected %h, actual %h (x_sample %h)",
                   pending_i0[0], out_i0_value, pending_x[0]);
            error_count++;
          end
          void'(pending_i0.pop_front());
          void'(pending_x.pop_front());
          results_checked++;
        end
      end
    end
  end

  // The watchdog counts the cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_i0.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // This task sends one sample. It is entered just after a falling edge. It may first idle at
  // random. It then holds the sample until a transfer completes and returns on the
  // next falling edge, so that the caller can drive the following sample or lower valid.
  task automatic send_sample(input logic signed [bi0_pkg::X_W-1:0] x);
    while (!no_idle && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_x_sample <= x;
    do begin
      @(posedge clk);
    end while (in_stall);
    samples_sent++;
    @(negedge clk);
  endtask

  // This test covers the directed corners: zero, the smallest steps either side of zero, the
  // most positive and most negative codes, and whole and half units. It also sends
  // alternating bit patterns. The most negative code is the case in which the magnitude
  // needs the full 16 bits. Near |x| = 8 the accumulator comes closest to its limit.
  task automatic test_directed_corners();
    logic signed [bi0_pkg::X_W-1:0] corners[$];
    corners = {16'sh0000, 16'sh0001, -16'sh0001, 16'sh7FFF, -16'sh8000, 16'sh7FFE,
               -16'sh7FFF, 16'sh1000, -16'sh1000, 16'sh0800, 16'sh2000, 16'sh4000,
               -16'sh4000, 16'sh6000, 16'sh7000, -16'sh7000, 16'sh5555, -16'sh5556,
               16'sh00FF, 16'sh0100, -16'sh2001, 16'sh3FFF};
    foreach (corners[i]) begin
      send_sample(corners[i]);
    end
  endtask

  // This test sends arguments drawn uniformly from every 16-bit code, so that every bit of
  // the sample takes both values.
  task automatic test_random_full_range(input int count);
    repeat (count) begin
      send_sample(bi0_pkg::X_W'($urandom));
    end
  endtask

  // This test clusters the arguments near zero, where the higher terms vanish, and near
  // both ends of the range, where every term counts.
  task automatic test_random_near_edges(input int count);
    int pick;
    logic signed [bi0_pkg::X_W-1:0] x;
    repeat (count) begin
      pick = $urandom_range(0, 2);
      case (pick)
        0:       x = bi0_pkg::X_W'($urandom_range(0, 511)) - 16'sd256;
        1:       x = 16'sh7FFF - bi0_pkg::X_W'($urandom_range(0, 1023));
        default: x = -16'sh8000 + bi0_pkg::X_W'($urandom_range(0, 1023));
      endcase
      send_sample(x);
    end
  endtask

  // This test sends a long burst with no idling on either side. Here the pipeline runs full
  // at one transfer per cycle.
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count) begin
      send_sample(bi0_pkg::X_W'($urandom));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_corners();
    test_random_full_range(330);
    test_random_near_edges(200);
    test_back_to_back(250);
    test_random_full_range(70);
    in_valid <= 1'b0;

    // Wait for every outstanding result to arrive. After that the bench lets the pipeline
    // drain with the result side never stalled, so that any result that should not exist
    // shows up.
    while (pending_i0.size() != 0) begin
      @(posedge clk);
    end
    no_idle = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples (directed corners, full-range, near-edge, back-to-back)",
             samples_sent);
    $display("and checked %0d I0 results under random stalls on both channels.",
             results_checked);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/bi0_pkg.sv
rtl/bi0_square.sv
rtl/bi0_horner_step.sv
rtl/bessel_i0_poly_eval.sv
rtl/bi0_checker.sv
bench/tb_top.sv
